// ----- hw/rtl/sle_pkg.sv -----
// Shared types and constants of the sequential list engine.
package sle_pkg;

  localparam int unsigned CAPACITY_DEF = 32;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_DELETE = 2'd1,
    FUNC_FIND   = 2'd2,
    FUNC_NOP    = 2'd3
  } sle_func_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_BADPOS   = 2'd2,
    STAT_NOTFOUND = 2'd3
  } sle_status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_LAST,
    ST_FINISH
  } sle_state_e;

  typedef struct packed {
    sle_status_e status;
    logic [4:0]  found_index;
    logic [5:0]  list_count;
  } sle_res_t;

endpackage

// ----- hw/rtl/sle_req_if.sv -----
// Request channel of the sequential list engine.
interface sle_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [5:0]         position;
  logic signed [31:0] value;

  modport source (output valid, func, position, value, input ready);
  modport sink (input valid, func, position, value, output ready);
endinterface

// ----- hw/rtl/sle_rsp_if.sv -----
// Result channel of the sequential list engine.
interface sle_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [4:0] found_index;
  logic [5:0] list_count;

  modport source (output valid, status, found_index, list_count, input ready);
  modport sink (input valid, status, found_index, list_count, output ready);
endinterface

// ----- hw/rtl/sle_mem.sv -----
// Element store: one write port and one read port with registered read data.
module sle_mem #(
  parameter int unsigned DEPTH = sle_pkg::CAPACITY_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/sle_fsm.sv -----
// Sequencer that walks the element store one entry per cycle for each request.
module sle_fsm #(
  parameter int unsigned CAPACITY = sle_pkg::CAPACITY_DEF,
  parameter int unsigned AW       = $clog2(CAPACITY),
  parameter int unsigned CW       = $clog2(CAPACITY + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  sle_req_if.sink           req_i,
  output logic              mem_re_o,
  output logic [AW-1:0]     mem_raddr_o,
  output logic              mem_we_o,
  output logic [AW-1:0]     mem_waddr_o,
  output logic [31:0]       mem_wdata_o,
  input  logic [31:0]       mem_rdata_i,
  output logic              res_valid_o,
  output sle_pkg::sle_res_t res_o,
  input  logic              res_ready_i
);

  localparam int unsigned PW = ((CW > 6) ? CW : 6) + 1;

  sle_pkg::sle_state_e  state_q, state_d;
  sle_pkg::sle_func_e   op_q, op_d;
  sle_pkg::sle_status_e status_q, status_d;
  logic [31:0]          word_q, word_d;
  logic [AW-1:0]        idx_q, idx_d;
  logic [AW-1:0]        rd_addr_q, rd_addr_d;
  logic [AW-1:0]        pend_addr_q, pend_addr_d;
  logic [AW-1:0]        hit_q, hit_d;
  logic [CW-1:0]        rem_q, rem_d;
  logic [CW-1:0]        count_q, count_d;
  logic                 pend_q, pend_d;
  logic [PW-1:0]        pos_x, n_x;
  logic                 issue;

  assign pos_x = PW'(req_i.position);
  assign n_x   = PW'(count_q);
  assign issue = (rem_q != '0);

  assign req_i.ready = (state_q == sle_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sle_pkg::ST_IDLE;
      count_q <= '0;
      rem_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rem_q   <= rem_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    status_q    <= status_d;
    word_q      <= word_d;
    idx_q       <= idx_d;
    rd_addr_q   <= rd_addr_d;
    pend_addr_q <= pend_addr_d;
    hit_q       <= hit_d;
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    status_d    = status_q;
    word_d      = word_q;
    idx_d       = idx_q;
    rd_addr_d   = rd_addr_q;
    pend_addr_d = pend_addr_q;
    hit_d       = hit_q;
    rem_d       = rem_q;
    count_d     = count_q;
    pend_d      = 1'b0;
    mem_re_o    = 1'b0;
    mem_raddr_o = rd_addr_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = pend_addr_q;
    mem_wdata_o = mem_rdata_i;
    res_valid_o = 1'b0;

    unique case (state_q)
      sle_pkg::ST_IDLE: begin
        if (req_i.valid) begin
          op_d     = sle_pkg::sle_func_e'(req_i.func);
          word_d   = req_i.value;
          hit_d    = '0;
          status_d = sle_pkg::STAT_OK;
          unique case (sle_pkg::sle_func_e'(req_i.func))
            sle_pkg::FUNC_INSERT: begin
              if (count_q == CW'(CAPACITY)) begin
                status_d = sle_pkg::STAT_FULL;
                state_d  = sle_pkg::ST_FINISH;
              end else if (pos_x == '0 || pos_x > n_x + PW'(1)) begin
                status_d = sle_pkg::STAT_BADPOS;
                state_d  = sle_pkg::ST_FINISH;
              end else begin
                // Entries from the tail down to the target move up by one.
                idx_d     = AW'(pos_x - PW'(1));
                rem_d     = CW'(n_x + PW'(1) - pos_x);
                rd_addr_d = AW'(n_x - PW'(1));
                state_d   = (n_x + PW'(1) == pos_x) ? sle_pkg::ST_LAST
                                                    : sle_pkg::ST_WALK;
              end
            end
            sle_pkg::FUNC_DELETE: begin
              if (pos_x == '0 || pos_x > n_x) begin
                status_d = sle_pkg::STAT_BADPOS;
                state_d  = sle_pkg::ST_FINISH;
              end else if (pos_x == n_x) begin
                count_d = count_q - CW'(1);
                state_d = sle_pkg::ST_FINISH;
              end else begin
                // Entries after the target move down by one.
                rem_d     = CW'(n_x - pos_x);
                rd_addr_d = AW'(pos_x);
                state_d   = sle_pkg::ST_WALK;
              end
            end
            sle_pkg::FUNC_FIND: begin
              if (count_q == '0) begin
                status_d = sle_pkg::STAT_NOTFOUND;
                state_d  = sle_pkg::ST_FINISH;
              end else begin
                rem_d     = count_q;
                rd_addr_d = '0;
                state_d   = sle_pkg::ST_WALK;
              end
            end
            sle_pkg::FUNC_NOP: begin
              state_d = sle_pkg::ST_FINISH;
            end
            default: begin
              state_d = sle_pkg::ST_FINISH;
            end
          endcase
        end
      end

      sle_pkg::ST_WALK: begin
        // One read is issued per cycle; the word read in the previous cycle
        // is written back one place over, or compared for a find.
        if (issue) begin
          mem_re_o = 1'b1;
          rem_d    = rem_q - CW'(1);
          pend_d   = 1'b1;
          if (op_q == sle_pkg::FUNC_INSERT) begin
            rd_addr_d   = rd_addr_q - AW'(1);
            pend_addr_d = rd_addr_q + AW'(1);
          end else if (op_q == sle_pkg::FUNC_DELETE) begin
            rd_addr_d   = rd_addr_q + AW'(1);
            pend_addr_d = rd_addr_q - AW'(1);
          end else begin
            rd_addr_d   = rd_addr_q + AW'(1);
            pend_addr_d = rd_addr_q;
          end
        end
        if (pend_q) begin
          if (op_q == sle_pkg::FUNC_FIND) begin
            if (mem_rdata_i == word_q) begin
              hit_d    = pend_addr_q;
              status_d = sle_pkg::STAT_OK;
              rem_d    = '0;
              pend_d   = 1'b0;
              state_d  = sle_pkg::ST_FINISH;
            end else if (!issue) begin
              status_d = sle_pkg::STAT_NOTFOUND;
              state_d  = sle_pkg::ST_FINISH;
            end
          end else begin
            mem_we_o = 1'b1;
            if (!issue) begin
              if (op_q == sle_pkg::FUNC_INSERT) begin
                state_d = sle_pkg::ST_LAST;
              end else begin
                count_d = count_q - CW'(1);
                state_d = sle_pkg::ST_FINISH;
              end
            end
          end
        end
      end

      sle_pkg::ST_LAST: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_q;
        mem_wdata_o = word_q;
        count_d     = count_q + CW'(1);
        state_d     = sle_pkg::ST_FINISH;
      end

      sle_pkg::ST_FINISH: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = sle_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = sle_pkg::ST_IDLE;
      end
    endcase
  end

  assign res_o.status      = status_q;
  assign res_o.found_index = 5'(hit_q);
  assign res_o.list_count  = 6'(count_q);

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sle_pkg::ST_IDLE) |-> !mem_we_o)
    else $error("store written while idle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> (state_q != sle_pkg::ST_IDLE))
    else $error("accepted request did not start");

  a_count_at_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> (state_q == sle_pkg::ST_FINISH))
    else $error("entry count changed outside result hand-off");

endmodule

// ----- hw/rtl/sequential_list_engine.sv -----
// Top level of the sequential list engine: sequencer, element store, result register.
//
//   channel  dir  payload                              handshake
//   req_i    in   func, position, value                valid/ready
//   rsp_o    out  status, found_index, list_count      valid/ready
//
// A request is taken only while the sequencer is idle. An insert moves the
// entries from the tail down to the target up by one, then writes the new
// word; a delete moves the entries after the target down by one. A find
// walks from the head and stops at the first match. The slowest items are
// an insert at the head of a list holding CAPACITY - 1 entries and a find
// that matches nothing in a full list. Rejected requests, a delete at the
// tail, a find on an empty list and the unused code go straight to the
// result.
// Reset clears the entry count to an empty list; the store itself is not
// cleared because only entries below the count are ever read.
// The result sits in an output register, so a new request can be accepted
// while the previous result still waits on a stalled sink.
module sequential_list_engine #(
  parameter int unsigned CAPACITY = sle_pkg::CAPACITY_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  sle_req_if.sink  req_i,
  sle_rsp_if.source rsp_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [31:0]       mem_wdata;
  logic [31:0]       mem_rdata;
  logic              res_valid;
  logic              res_ready;
  sle_pkg::sle_res_t res;

  // Output register: holds one finished result until the sink takes it.
  logic              out_valid_q;
  sle_pkg::sle_res_t out_q;

  sle_fsm #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  sle_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // The register can take a new result when empty or when drained this cycle.
  assign res_ready = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_q.status;
  assign rsp_o.found_index = out_q.found_index;
  assign rsp_o.list_count  = out_q.list_count;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the sequential list engine: directed table, then random traffic.
module tb;

  localparam int CAP          = sle_pkg::CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 1700;
  localparam int PHASE_ITEMS  = 100;
  // The slowest operations are an insert at the head of an almost full list and a find that misses in a full list.
  localparam int SETTLE_CYCLES = CAP + 24;

  typedef struct packed {
    sle_pkg::sle_func_e func;
    logic [5:0]         position;
    logic signed [31:0] value;
  } list_req_t;

  // One row of the directed table. When known is set, res is the result
  // to expect; otherwise the list predictor supplies it.
  typedef struct packed {
    list_req_t         req;
    logic              known;
    sle_pkg::sle_res_t res;
  } dir_row_t;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED} traffic_mix_e;

  localparam dir_row_t DIRECTED [25] = '{
    '{'{sle_pkg::FUNC_FIND, 6'd0, 32'h0000_0000}, 1'b1, '{sle_pkg::STAT_NOTFOUND, 5'd0, 6'd0}},
    '{'{sle_pkg::FUNC_DELETE, 6'd1, 32'h0000_0000}, 1'b1, '{sle_pkg::STAT_BADPOS, 5'd0, 6'd0}},
    '{'{sle_pkg::FUNC_INSERT, 6'd0, 32'h0000_0001}, 1'b1, '{sle_pkg::STAT_BADPOS, 5'd0, 6'd0}},
    '{'{sle_pkg::FUNC_INSERT, 6'd2, 32'h0000_0001}, 1'b1, '{sle_pkg::STAT_BADPOS, 5'd0, 6'd0}},
    '{'{sle_pkg::FUNC_INSERT, 6'd1, 32'h7FFF_FFFF}, 1'b1, '{sle_pkg::STAT_OK, 5'd0, 6'd1}},
    '{'{sle_pkg::FUNC_INSERT, 6'd1, 32'h8000_0000}, 1'b1, '{sle_pkg::STAT_OK, 5'd0, 6'd2}},
    '{'{sle_pkg::FUNC_INSERT, 6'd3, 32'hFFFF_FFFF}, 1'b1, '{sle_pkg::STAT_OK, 5'd0, 6'd3}},
    '{'{sle_pkg::FUNC_FIND, 6'd0, 32'h7FFF_FFFF}, 1'b1, '{sle_pkg::STAT_OK, 5'd1, 6'd3}},
    '{'{sle_pkg::FUNC_FIND, 6'd63, 32'hFFFF_FFFF}, 1'b1, '{sle_pkg::STAT_OK, 5'd2, 6'd3}},
    '{'{sle_pkg::FUNC_FIND, 6'd0, 32'h8000_0000}, 1'b1, '{sle_pkg::STAT_OK, 5'd0, 6'd3}},
    '{'{sle_pkg::FUNC_FIND, 6'd0, 32'h0000_0000}, 1'b1, '{sle_pkg::STAT_NOTFOUND, 5'd0, 6'd3}},
    '{'{sle_pkg::FUNC_NOP, 6'd63, 32'hFFFF_FFFF}, 1'b1, '{sle_pkg::STAT_OK, 5'd0, 6'd3}},
    '{'{sle_pkg::FUNC_DELETE, 6'd4, 32'h0000_0000}, 1'b1, '{sle_pkg::STAT_BADPOS, 5'd0, 6'd3}},
    '{'{sle_pkg::FUNC_DELETE, 6'd63, 32'h0000_0000}, 1'b1, '{sle_pkg::STAT_BADPOS, 5'd0, 6'd3}},
    '{'{sle_pkg::FUNC_INSERT, 6'd5, 32'h0000_0002}, 1'b1, '{sle_pkg::STAT_BADPOS, 5'd0, 6'd3}},
    '{'{sle_pkg::FUNC_INSERT, 6'd63, 32'h0000_0002}, 1'b1, '{sle_pkg::STAT_BADPOS, 5'd0, 6'd3}},
    '{'{sle_pkg::FUNC_DELETE, 6'd2, 32'h0000_0000}, 1'b1, '{sle_pkg::STAT_OK, 5'd0, 6'd2}},
    '{'{sle_pkg::FUNC_FIND, 6'd0, 32'h7FFF_FFFF}, 1'b1, '{sle_pkg::STAT_NOTFOUND, 5'd0, 6'd2}},
    '{'{sle_pkg::FUNC_INSERT, 6'd2, 32'h5A5A_A5A5}, 1'b0, '{sle_pkg::STAT_OK, 5'd0, 6'd0}},
    '{'{sle_pkg::FUNC_INSERT, 6'd2, 32'hFFFF_FFFF}, 1'b0, '{sle_pkg::STAT_OK, 5'd0, 6'd0}},
    '{'{sle_pkg::FUNC_FIND, 6'd0, 32'hFFFF_FFFF}, 1'b0, '{sle_pkg::STAT_OK, 5'd0, 6'd0}},
    '{'{sle_pkg::FUNC_DELETE, 6'd1, 32'h0000_0000}, 1'b0, '{sle_pkg::STAT_OK, 5'd0, 6'd0}},
    '{'{sle_pkg::FUNC_DELETE, 6'd3, 32'h0000_0000}, 1'b0, '{sle_pkg::STAT_OK, 5'd0, 6'd0}},
    '{'{sle_pkg::FUNC_FIND, 6'd0, 32'h5A5A_A5A5}, 1'b0, '{sle_pkg::STAT_OK, 5'd0, 6'd0}},
    '{'{sle_pkg::FUNC_DELETE, 6'd0, 32'h0000_0000}, 1'b1, '{sle_pkg::STAT_BADPOS, 5'd0, 6'd2}}
  };

  logic clk;
  logic rst_n;

  sle_req_if req_if ();
  sle_rsp_if rsp_if ();

  sequential_list_engine u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Predicted contents of the list and the results still to arrive.
  logic signed [31:0] list_words [CAP];
  int                 list_len;
  sle_pkg::sle_res_t  expected_results [$];
  int                 mismatch_count;
  bit                 req_burst;
  bit                 rsp_burst;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Applies one request to the predicted list and returns its result.
  function automatic sle_pkg::sle_res_t apply_request(input list_req_t r);
    sle_pkg::sle_res_t res;
    int                pos;
    int                k;
    bit                hit;
    pos             = int'(r.position);
    hit             = 1'b0;
    res.status      = sle_pkg::STAT_OK;
    res.found_index = '0;
    case (r.func)
      sle_pkg::FUNC_INSERT: begin
        // A full list is reported before the position is looked at.
        if (list_len >= CAP) begin
          res.status = sle_pkg::STAT_FULL;
        end else if (pos < 1 || pos > list_len + 1) begin
          res.status = sle_pkg::STAT_BADPOS;
        end else begin
          for (k = list_len; k >= pos; k--) list_words[k] = list_words[k - 1];
          list_words[pos - 1] = r.value;
          list_len++;
        end
      end
      sle_pkg::FUNC_DELETE: begin
        if (pos < 1 || pos > list_len) begin
          res.status = sle_pkg::STAT_BADPOS;
        end else begin
          for (k = pos; k < list_len; k++) list_words[k - 1] = list_words[k];
          list_len--;
        end
      end
      sle_pkg::FUNC_FIND: begin
        res.status = sle_pkg::STAT_NOTFOUND;
        for (k = 0; k < list_len; k++) begin
          if (!hit && list_words[k] == r.value) begin
            hit             = 1'b1;
            res.status      = sle_pkg::STAT_OK;
            res.found_index = 5'(k);
          end
        end
      end
      default: ;
    endcase
    res.list_count = 6'(list_len);
    return res;
  endfunction

  // Small values repeat often, so finds meet duplicates and first-match matters.
  function automatic logic signed [31:0] pick_value();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 5) return int'($urandom_range(0, 7)) - 4;
    if (roll < 6) return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    return $urandom;
  endfunction

  // Mostly well-formed requests against the current list, with some noise.
  function automatic list_req_t make_request(input traffic_mix_e mix);
    list_req_t r;
    int        roll;
    int        ins_pct;
    int        del_pct;
    r.func     = sle_pkg::sle_func_e'($urandom_range(0, 3));
    r.position = 6'($urandom_range(0, 63));
    r.value    = $urandom;
    if ($urandom_range(0, 99) < 10) return r;
    case (mix)
      MIX_FILL: begin
        ins_pct = 70;
        del_pct = 10;
      end
      MIX_DRAIN: begin
        ins_pct = 15;
        del_pct = 65;
      end
      default: begin
        ins_pct = 40;
        del_pct = 30;
      end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < ins_pct) begin
      r.func     = sle_pkg::FUNC_INSERT;
      r.position = 6'($urandom_range(1, list_len + 1));
      r.value    = pick_value();
    end else if (roll < ins_pct + del_pct) begin
      r.func     = sle_pkg::FUNC_DELETE;
      r.position = (list_len > 0) ? 6'($urandom_range(1, list_len)) : 6'd1;
    end else begin
      r.func = sle_pkg::FUNC_FIND;
      if (list_len > 0 && $urandom_range(0, 1) == 1)
        r.value = list_words[$urandom_range(0, list_len - 1)];
      else
        r.value = pick_value();
    end
    return r;
  endfunction

  // Offers one item after a random gap (none in a burst) and records its result once taken.
  // Valid stays high after acceptance so that back-to-back items need no
  // second assignment in the same time step.
  task automatic send_request(input list_req_t r, input logic known,
                              input sle_pkg::sle_res_t known_res);
    int                gap;
    sle_pkg::sle_res_t res;
    gap = req_burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.func     <= r.func;
    req_if.position <= r.position;
    req_if.value    <= r.value;
    do @(posedge clk); while (!req_if.ready);
    res = apply_request(r);
    expected_results.push_back(known ? known_res : res);
  endtask

  // Stimulus: reset, directed table, then phases of random traffic.
  initial begin
    list_req_t    r;
    traffic_mix_e mix;
    int           phase;
    int           n;
    rst_n           = 1'b0;
    req_if.valid    = 1'b0;
    req_if.func     = sle_pkg::FUNC_NOP;
    req_if.position = '0;
    req_if.value    = '0;
    list_len        = 0;
    mismatch_count  = 0;
    req_burst       = 1'b0;
    rsp_burst       = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i]) send_request(DIRECTED[i].req, DIRECTED[i].known, DIRECTED[i].res);

    for (phase = 0; phase < RANDOM_ITEMS / PHASE_ITEMS; phase++) begin
      // Now and then the sender holds off until every result has drained.
      if (phase == 8 || $urandom_range(0, 7) == 0) begin
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
      end
      case (phase % 4)
        0:       mix = MIX_FILL;
        2:       mix = MIX_DRAIN;
        default: mix = MIX_BALANCED;
      endcase
      req_burst = ($urandom_range(0, 3) == 0);
      rsp_burst = ($urandom_range(0, 3) == 0);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        r = make_request(mix);
        send_request(r, 1'b0, '0);
      end
    end

    req_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Result side: random stalls (none in a burst), then each accepted result against the oldest expectation.
  initial begin
    int                stall;
    sle_pkg::sle_res_t want;
    rsp_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = rsp_burst ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!rsp_if.valid);
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d, found_index %0d, list_count %0d",
               rsp_if.status, rsp_if.found_index, rsp_if.list_count);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (rsp_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_if.status);
          mismatch_count++;
        end
        if (rsp_if.found_index !== want.found_index) begin
          $error("found_index: expected %0d, got %0d", want.found_index, rsp_if.found_index);
          mismatch_count++;
        end
        if (rsp_if.list_count !== want.list_count) begin
          $error("list_count: expected %0d, got %0d", want.list_count, rsp_if.list_count);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: well beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
